[src/miex_pkg.sv]
// Package for the mini ISA execute unit: opcode and branch condition codes,
// request and response payload structs. No dependencies.
package miex_pkg;

   localparam int DATA_W = 64;
   localparam int IDX_W  = 5;
   localparam int SH_W   = 6;

   typedef enum logic [3:0] {
      ACT_MOV     = 4'd0,
      ACT_ADD     = 4'd1,
      ACT_SUB     = 4'd2,
      ACT_CMP     = 4'd3,
      ACT_CMPU    = 4'd4,
      ACT_AND     = 4'd5,
      ACT_XOR     = 4'd6,
      ACT_OR      = 4'd7,
      ACT_ASR     = 4'd8,
      ACT_LSL     = 4'd9,
      ACT_LSR     = 4'd10,
      ACT_BRANCH  = 4'd11
   } action_type;

   typedef enum logic [2:0] {
      COND_ALWAYS = 3'd0,
      COND_EQ     = 3'd1,
      COND_NE     = 3'd2,
      COND_GT     = 3'd3,
      COND_GE     = 3'd4,
      COND_LT     = 3'd5,
      COND_LE     = 3'd6
   } cond_type;

   typedef struct packed {
      action_type               action;
      logic [IDX_W-1:0]         dest_index;
      logic [IDX_W-1:0]         src_a_index;
      logic [IDX_W-1:0]         src_b_index;
      logic signed [DATA_W-1:0] immediate;
      logic                     a_is_immediate;
      logic                     b_is_immediate;
      logic [SH_W-1:0]          shift_amount;
      cond_type                 condition;
   } req_type;

   typedef struct packed {
      logic                     write_enable;
      logic [IDX_W-1:0]         write_index;
      logic signed [DATA_W-1:0] write_value;
      logic                     branch_taken;
      logic                     flag_greater;
      logic                     flag_equal;
      logic                     flag_less;
   } rsp_type;

   typedef struct packed {
      logic greater;
      logic equal;
      logic less;
   } flags_type;

endpackage

[src/mini_isa_execute_unit.sv]
// Top level of the mini ISA execute unit: register file, compare flags, ALU.
// Depends on miex_pkg and miex_ram.
//
// One instruction is taken per cycle when the response side does not stall,
// and each produces one response, held in the response register. The
// register file is kept in three copies of a one-read-port RAM (first source,
// second source, destination); the read is started at the request transfer
// and the ALU, compare and branch logic sit between the RAM read register
// and the response register. A value written in the cycle of a read is
// forwarded. Per-register valid bits make every register read zero after
// reset, so no clearing pass is needed.
module mini_isa_execute_unit
   import miex_pkg::*;
#(
   parameter int NUM_REGS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int AW = $clog2(NUM_REGS);
   localparam int NPORTS = 3;

   logic                 req_xfer;
   logic                 advance;
   logic                 s1_valid_ff;
   req_type              s1_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   flags_type            flags_ff;
   flags_type            flags_in;
   logic [NUM_REGS-1:0]  reg_valid_ff;
   logic [DATA_W-1:0]    fwd_value_ff;
   logic [NPORTS-1:0]    op_fwd_ff;
   logic [NPORTS-1:0]    op_zero_ff;
   logic [IDX_W-1:0]     rd_idx [NPORTS];
   logic [AW-1:0]        rd_addr [NPORTS];
   logic [DATA_W-1:0]    ram_q [NPORTS];
   logic [DATA_W-1:0]    ops [NPORTS];
   logic [NPORTS-1:0]    fwd_hit;
   logic [NPORTS-1:0]    rd_zero;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [DATA_W-1:0]    val;
   logic                 writes;
   logic                 taken;
   logic [DATA_W-1:0]    ra;
   logic [DATA_W-1:0]    rb;
   logic [DATA_W-1:0]    left;
   logic [DATA_W-1:0]    opb;
   logic [DATA_W-1:0]    right;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign rd_idx[0] = req_payload.src_a_index;
   assign rd_idx[1] = req_payload.src_b_index;
   assign rd_idx[2] = req_payload.dest_index;

   assign wr_en   = advance && rsp_in.write_enable;
   assign wr_addr = AW'(s1_ff.dest_index);

   for (genvar p = 0; p < NPORTS; p++) begin : g_port
      assign rd_addr[p] = AW'(rd_idx[p]);
      assign fwd_hit[p] = wr_en && (s1_ff.dest_index == rd_idx[p]);
      assign rd_zero[p] = !(int'(rd_idx[p]) < NUM_REGS)
                          || (!reg_valid_ff[rd_addr[p]] && !fwd_hit[p]);
      assign ops[p] = op_zero_ff[p] ? '0 : (op_fwd_ff[p] ? fwd_value_ff : ram_q[p]);

      miex_ram #(
         .WIDTH(DATA_W),
         .DEPTH(NUM_REGS)
      ) u_ram (
         .clock  (clock),
         .wr_en  (wr_en),
         .wr_addr(wr_addr),
         .wr_data(val),
         .rd_en  (req_xfer),
         .rd_addr(rd_addr[p]),
         .rd_data(ram_q[p])
      );
   end

   assign ra    = ops[0];
   assign rb    = ops[1];
   assign left  = ops[2];
   assign opb   = s1_ff.b_is_immediate ? s1_ff.immediate : rb;
   assign right = s1_ff.a_is_immediate ? s1_ff.immediate : ra;

   always_comb begin
      val      = '0;
      writes   = 1'b0;
      taken    = 1'b0;
      flags_in = flags_ff;
      case (s1_ff.action)
         ACT_MOV: begin
            val    = s1_ff.immediate;
            writes = 1'b1;
         end
         ACT_ADD: begin
            val    = ra + opb;
            writes = 1'b1;
         end
         ACT_SUB: begin
            val    = ra - opb;
            writes = 1'b1;
         end
         ACT_CMP: begin
            flags_in.greater = $signed(left) > $signed(right);
            flags_in.less    = $signed(left) < $signed(right);
            flags_in.equal   = left == right;
         end
         ACT_CMPU: begin
            flags_in.greater = left > right;
            flags_in.less    = left < right;
            flags_in.equal   = left == right;
         end
         ACT_AND: begin
            val    = ra & rb;
            writes = 1'b1;
         end
         ACT_XOR: begin
            val    = ra ^ rb;
            writes = 1'b1;
         end
         ACT_OR: begin
            val    = ra | rb;
            writes = 1'b1;
         end
         ACT_ASR: begin
            val    = $unsigned($signed(ra) >>> s1_ff.shift_amount);
            writes = 1'b1;
         end
         ACT_LSL: begin
            val    = ra << s1_ff.shift_amount;
            writes = 1'b1;
         end
         ACT_LSR: begin
            val    = ra >> s1_ff.shift_amount;
            writes = 1'b1;
         end
         ACT_BRANCH: begin
            unique case (s1_ff.condition)
               COND_ALWAYS: taken = 1'b1;
               COND_EQ:     taken = flags_ff.equal && !flags_ff.greater && !flags_ff.less;
               COND_NE:     taken = !flags_ff.equal;
               COND_GT:     taken = flags_ff.greater && !flags_ff.equal;
               COND_GE:     taken = flags_ff.greater || flags_ff.equal;
               COND_LT:     taken = flags_ff.less && !flags_ff.equal;
               COND_LE:     taken = flags_ff.less || flags_ff.equal;
               default:     taken = 1'b0;
            endcase
         end
         default: ;
      endcase
      if (!(int'(s1_ff.dest_index) < NUM_REGS)) begin
         writes = 1'b0;
      end
      rsp_in.write_enable = writes;
      rsp_in.write_index  = writes ? s1_ff.dest_index : '0;
      rsp_in.write_value  = writes ? val : '0;
      rsp_in.branch_taken = taken;
      rsp_in.flag_greater = flags_in.greater;
      rsp_in.flag_equal   = flags_in.equal;
      rsp_in.flag_less    = flags_in.less;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         reg_valid_ff <= '0;
      end else begin
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            flags_ff     <= flags_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            reg_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ff        <= req_payload;
         fwd_value_ff <= val;
         op_fwd_ff    <= fwd_hit;
         op_zero_ff   <= rd_zero;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_flags_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0({flags_ff.greater, flags_ff.equal, flags_ff.less}))
      else $error("more than one compare flag set");

   a_accept_needs_advance: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && s1_valid_ff) |-> advance)
      else $error("request taken while execute stage is held");

   a_no_write_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.write_enable) |->
         (rsp_payload.write_index == '0 && rsp_payload.write_value == '0))
      else $error("write fields not cleared without write");

   a_branch_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.branch_taken) |-> !rsp_payload.write_enable)
      else $error("taken branch also writes a register");
`endif

endmodule

[src/miex_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module miex_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[test/miex_checker.sv]
// Checker for the mini ISA execute unit: watches request and response transfers,
// keeps its own register file and compare flags, and compares every response.
// Depends on miex_pkg.
module miex_checker
   import miex_pkg::*;
#(
   parameter int NUM_REGS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      failures,
   output int      outstanding
);

   logic [DATA_W-1:0] reg_values [2**IDX_W];
   flags_type         cmp_flags;
   rsp_type           pending_results [$];
   int                mismatch_count;
   int                rsp_count;

   function automatic logic [DATA_W-1:0] read_reg(input logic [IDX_W-1:0] idx);
      return (idx < NUM_REGS) ? reg_values[idx] : '0;
   endfunction

   // Runs one instruction against the local state and returns its response.
   function automatic rsp_type execute_instruction(input req_type r);
      logic [DATA_W-1:0] src_a;
      logic [DATA_W-1:0] opnd_b;
      logic [DATA_W-1:0] left;
      logic [DATA_W-1:0] right;
      logic [DATA_W-1:0] result;
      logic              writes;
      logic              taken;
      rsp_type           res;
      src_a  = read_reg(r.src_a_index);
      opnd_b = r.b_is_immediate ? r.immediate : read_reg(r.src_b_index);
      left   = read_reg(r.dest_index);
      right  = r.a_is_immediate ? r.immediate : src_a;
      result = '0;
      writes = 1'b1;
      taken  = 1'b0;
      case (r.action)
         ACT_MOV: result = r.immediate;
         ACT_ADD: result = src_a + opnd_b;
         ACT_SUB: result = src_a - opnd_b;
         ACT_AND: result = src_a & read_reg(r.src_b_index);
         ACT_XOR: result = src_a ^ read_reg(r.src_b_index);
         ACT_OR:  result = src_a | read_reg(r.src_b_index);
         ACT_ASR: result = $signed(src_a) >>> r.shift_amount;
         ACT_LSL: result = src_a << r.shift_amount;
         ACT_LSR: result = src_a >> r.shift_amount;
         ACT_CMP: begin
            writes = 1'b0;
            cmp_flags.greater = $signed(left) > $signed(right);
            cmp_flags.less    = $signed(left) < $signed(right);
            cmp_flags.equal   = !cmp_flags.greater && !cmp_flags.less;
         end
         ACT_CMPU: begin
            writes = 1'b0;
            cmp_flags.greater = left > right;
            cmp_flags.less    = left < right;
            cmp_flags.equal   = !cmp_flags.greater && !cmp_flags.less;
         end
         ACT_BRANCH: begin
            writes = 1'b0;
            case (r.condition)
               COND_ALWAYS: taken = 1'b1;
               COND_EQ: taken = cmp_flags.equal && !cmp_flags.greater && !cmp_flags.less;
               COND_NE: taken = !cmp_flags.equal;
               COND_GT: taken = cmp_flags.greater && !cmp_flags.equal;
               COND_GE: taken = cmp_flags.greater || cmp_flags.equal;
               COND_LT: taken = cmp_flags.less && !cmp_flags.equal;
               COND_LE: taken = cmp_flags.less || cmp_flags.equal;
               default: taken = 1'b0;
            endcase
         end
         default: writes = 1'b0;
      endcase
      if (r.dest_index >= NUM_REGS)
         writes = 1'b0;
      if (writes)
         reg_values[r.dest_index] = result;
      res.write_enable = writes;
      res.write_index  = writes ? r.dest_index : '0;
      res.write_value  = writes ? result : '0;
      res.branch_taken = taken;
      res.flag_greater = cmp_flags.greater;
      res.flag_equal   = cmp_flags.equal;
      res.flag_less    = cmp_flags.less;
      return res;
   endfunction

   function automatic string show(input rsp_type r);
      return $sformatf("we=%0b idx=%0d val=%h br=%0b gt/eq/lt=%0b%0b%0b",
         r.write_enable, r.write_index, r.write_value, r.branch_taken,
         r.flag_greater, r.flag_equal, r.flag_less);
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%t checker: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (reg_values[i])
            reg_values[i] = '0;
         cmp_flags = '0;
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               note_failure($sformatf("unexpected response %0d: %s",
                  rsp_count, show(rsp_payload)));
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.write_enable !== want.write_enable ||
                   rsp_payload.write_index  !== want.write_index  ||
                   rsp_payload.write_value  !== want.write_value  ||
                   rsp_payload.branch_taken !== want.branch_taken ||
                   rsp_payload.flag_greater !== want.flag_greater ||
                   rsp_payload.flag_equal   !== want.flag_equal   ||
                   rsp_payload.flag_less    !== want.flag_less)
                  note_failure($sformatf("response %0d: expected %s, got %s",
                     rsp_count, show(want), show(rsp_payload)));
            end
            rsp_count++;
         end
         if (req_valid && req_ready)
            pending_results.push_back(execute_instruction(req_payload));
      end
      failures    <= mismatch_count;
      outstanding <= pending_results.size();
   end

endmodule

[test/tb_mini_isa_execute_unit.sv]
// Testbench top for mini_isa_execute_unit: directed then random instruction
// stream with random stalls on both sides; checking is done in miex_checker.
// Depends on miex_pkg, mini_isa_execute_unit and miex_checker.
module tb_mini_isa_execute_unit;
   import miex_pkg::*;

   localparam logic [3:0]        ACT_RESERVED_LO = 4'd12;
   localparam logic [3:0]        ACT_RESERVED_HI = 4'd15;
   localparam logic [2:0]        COND_NEVER      = 3'd7;
   localparam logic [DATA_W-1:0] MAX_POS         = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_NEG         = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] ALL_ONES        = '1;
   localparam action_type        ALU_OPS [8]     = '{ACT_ADD, ACT_SUB, ACT_AND, ACT_XOR,
                                                     ACT_OR, ACT_ASR, ACT_LSL, ACT_LSR};

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;
   int      failures;
   int      outstanding;
   bit      idle_on     = 1'b1;

   always #5 clock = ~clock;

   mini_isa_execute_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   miex_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .failures    (failures),
      .outstanding (outstanding)
   );

   function automatic req_type instr(input logic [3:0] act, input logic [IDX_W-1:0] dst,
                                     input logic [IDX_W-1:0] sa, input logic [IDX_W-1:0] sb,
                                     input logic [DATA_W-1:0] imm, input logic a_imm,
                                     input logic b_imm, input logic [SH_W-1:0] sh,
                                     input logic [2:0] cond);
      req_type r;
      r.action         = action_type'(act);
      r.dest_index     = dst;
      r.src_a_index    = sa;
      r.src_b_index    = sb;
      r.immediate      = imm;
      r.a_is_immediate = a_imm;
      r.b_is_immediate = b_imm;
      r.shift_amount   = sh;
      r.condition      = cond_type'(cond);
      return r;
   endfunction

   // Mostly a few low registers so that results feed later instructions.
   function automatic logic [IDX_W-1:0] pick_reg();
      return ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 3));
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      logic [3:0] low_bits;
      low_bits = 4'($urandom);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ALL_ONES;
         2: return MAX_POS;
         3: return MIN_NEG;
         4: return {{(DATA_W-4){low_bits[3]}}, low_bits};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_instr();
      logic [95:0] raw;
      req_type     r;
      int          pick;
      raw  = {$urandom, $urandom, $urandom};
      r    = raw[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 3)
         r.action = action_type'(4'($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI)));
      else if (pick < 12)
         r.action = ACT_MOV;
      else if (pick < 20)
         r.action = ACT_CMP;
      else if (pick < 26)
         r.action = ACT_CMPU;
      else if (pick < 40)
         r.action = ACT_BRANCH;
      else
         r.action = ALU_OPS[$urandom_range(0, 7)];
      r.dest_index  = pick_reg();
      r.src_a_index = pick_reg();
      r.src_b_index = pick_reg();
      r.immediate   = pick_value();
      return r;
   endfunction

   task automatic send(input req_type r);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // mov a value, compare it (mostly via the immediate) against itself or a neighbor, then branch on the flags
   task automatic compare_and_branch();
      logic [IDX_W-1:0]  d;
      logic [DATA_W-1:0] v;
      req_type           c;
      req_type           b;
      d = pick_reg();
      v = pick_value();
      send(instr(ACT_MOV, d, '0, '0, v, 1'b0, 1'b0, '0, COND_ALWAYS));
      c                = random_instr();
      c.action         = $urandom_range(0, 1) ? ACT_CMP : ACT_CMPU;
      c.dest_index     = d;
      c.a_is_immediate = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
         0: c.immediate = v;
         1: c.immediate = v + 1'b1;
         default: c.immediate = v - 1'b1;
      endcase
      send(c);
      b        = random_instr();
      b.action = ACT_BRANCH;
      send(b);
   endtask

   always begin
      @(posedge clock);
      if (!reset && idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      rsp_ready <= 1'b1;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int sent;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send(instr(ACT_MOV, 5'd1, '0, '0, MAX_POS, 1'b0, 1'b0, '0, COND_ALWAYS));
      send(instr(ACT_MOV, 5'd2, '0, '0, MIN_NEG, 1'b0, 1'b0, '0, COND_ALWAYS));
      send(instr(ACT_MOV, 5'd31, '0, '0, ALL_ONES, 1'b0, 1'b0, '0, COND_ALWAYS));
      send(instr(ACT_ADD, 5'd3, 5'd1, '0, 64'd1, 1'b0, 1'b1, '0, COND_ALWAYS));
      send(instr(ACT_SUB, 5'd4, 5'd2, 5'd1, '0, 1'b0, 1'b0, '0, COND_ALWAYS));
      send(instr(ACT_AND, 5'd6, 5'd31, 5'd1, '0, 1'b0, 1'b0, '0, COND_ALWAYS));
      send(instr(ACT_XOR, 5'd7, 5'd1, 5'd2, '0, 1'b0, 1'b0, '0, COND_ALWAYS));
      send(instr(ACT_OR, 5'd0, 5'd0, 5'd2, '0, 1'b0, 1'b0, '0, COND_ALWAYS));
      send(instr(ACT_ASR, 5'd9, 5'd2, '0, '0, 1'b0, 1'b0, 6'd63, COND_ALWAYS));
      send(instr(ACT_LSL, 5'd11, 5'd31, '0, '0, 1'b0, 1'b0, 6'd63, COND_ALWAYS));
      send(instr(ACT_LSR, 5'd13, 5'd31, '0, '0, 1'b0, 1'b0, 6'd63, COND_ALWAYS));
      send(instr(ACT_CMP, 5'd1, '0, '0, MIN_NEG, 1'b1, 1'b0, '0, COND_ALWAYS));
      send(instr(ACT_BRANCH, '0, '0, '0, '0, 1'b0, 1'b0, '0, COND_GT));
      send(instr(ACT_CMPU, 5'd1, 5'd2, '0, '0, 1'b0, 1'b0, '0, COND_ALWAYS));
      send(instr(ACT_BRANCH, '0, '0, '0, '0, 1'b0, 1'b0, '0, COND_LT));
      send(instr(ACT_CMP, 5'd3, 5'd0, '0, '0, 1'b0, 1'b0, '0, COND_ALWAYS));
      for (int c = COND_ALWAYS; c <= COND_NEVER; c++)
         send(instr(ACT_BRANCH, '0, '0, '0, '0, 1'b0, 1'b0, '0, 3'(c)));
      send(instr(ACT_RESERVED_LO, 5'd5, 5'd1, 5'd2, ALL_ONES, 1'b1, 1'b1, 6'd63, COND_NEVER));
      send(instr(ACT_RESERVED_HI, 5'd6, 5'd1, 5'd2, ALL_ONES, 1'b1, 1'b1, 6'd63, COND_NEVER));

      sent = 0;
      while (sent < 900) begin
         idle_on = (sent < 780) && ((sent / 130) % 3 != 2);
         if ($urandom_range(0, 3) == 0) begin
            compare_and_branch();
            sent += 3;
         end else begin
            send(random_instr());
            sent++;
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[mini_isa_execute_unit.f]
src/miex_pkg.sv
src/miex_ram.sv
src/mini_isa_execute_unit.sv
test/miex_checker.sv
test/tb_mini_isa_execute_unit.sv
